@@ hdl/hdr_pixel_tonemap_lut_core_macros.svh @@
// Assertion macros shared by the tone-mapping core.
`ifndef HDR_PIXEL_TONEMAP_LUT_CORE_MACROS_SVH
`define HDR_PIXEL_TONEMAP_LUT_CORE_MACROS_SVH

`ifndef SYNTH
// Checks that a condition implies another one in the same cycle.
`define HTM_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// Checks that a condition implies another one in the next cycle.
`define HTM_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`else
`define HTM_ASSERT_SAME(label, clk, rst, cond, prop, msg)
`define HTM_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif

`endif

@@ hdl/hdrtm_pkg.sv @@
// Types, constants and arithmetic helpers of the tone-mapping core.
package hdrtm_pkg;

   typedef enum logic [1:0] {
      ACT_PIXEL     = 2'd0,
      ACT_WR_LUMA   = 2'd1,
      ACT_WR_LINEAR = 2'd2,
      ACT_WR_SDR    = 2'd3
   } action_type;

   // Request fields carried down the pipeline.
   typedef struct packed {
      action_type  action;
      logic [11:0] addr;
      logic [15:0] data;
      logic        custom;
      logic [7:0]  cb_cust;
      logic [7:0]  cr_cust;
   } item_type;

   // Q16 coefficients; the chroma scales are Q8.
   localparam logic [17:0] PQ_CR_COEF  = 18'd96639;
   localparam logic [17:0] PQ_CB_COEF  = 18'd123299;
   localparam logic [16:0] R2020_COEF  = 17'd17217;
   localparam logic [16:0] B2020_COEF  = 17'd3886;
   localparam logic [16:0] G2020_INV   = 17'd96660;
   localparam logic [16:0] R709_COEF   = 17'd13933;
   localparam logic [16:0] G709_COEF   = 17'd46871;
   localparam logic [16:0] B709_COEF   = 17'd4732;
   localparam logic [16:0] CB709_COEF  = 17'd35318;
   localparam logic [16:0] CR709_COEF  = 17'd41615;
   localparam logic [7:0]  CB_SCALE    = 8'd242;
   localparam logic [7:0]  CR_SCALE    = 8'd235;
   localparam logic [9:0]  CB_OFFSET   = 10'd484;
   localparam logic [9:0]  CR_OFFSET   = 10'd470;
   localparam logic [9:0]  CODE_MAX    = 10'h3FF;

   // Rebuilds one PQ-coded color channel from luma and a chroma sample.
   function automatic logic [9:0] pq_channel(input logic [9:0] y, input logic [9:0] c,
                                             input logic [17:0] coef);
      logic signed [31:0] s;
      s = $signed({6'b0, y, 16'b0}) + $signed({14'b0, coef}) *
          ($signed({22'b0, c}) - 32'sd512) + 32'sd32768;
      if (s < 0) begin
         return 10'd0;
      end else if (s[31:16] > 16'(CODE_MAX)) begin
         return CODE_MAX;
      end
      return s[25:16];
   endfunction

   // Scales chroma by a fixed factor around the offset, with clamping.
   function automatic logic [7:0] custom_chroma(input logic [9:0] c, input logic [7:0] scale,
                                                input logic [9:0] offs);
      logic [17:0]        p;
      logic signed [11:0] q;
      p = 18'(c) * 18'(scale);
      q = $signed(12'(p[17:8])) - $signed(12'(offs));
      if (q < -12'sd128) begin
         q = -12'sd128;
      end
      if (q > 12'sd127) begin
         q = 12'sd127;
      end
      q = q + 12'sd128;
      return q[7:0];
   endfunction

   // BT.709 chroma from a color difference, with rounding and clamping.
   function automatic logic [7:0] chroma_709(input logic [7:0] a, input logic [7:0] yv,
                                             input logic [16:0] coef);
      logic signed [9:0]  d;
      logic signed [31:0] s;
      d = $signed({2'b0, a}) - $signed({2'b0, yv});
      s = 32'(d) * $signed({15'b0, coef}) + 32'sd8421376;
      if (s < 0) begin
         return 8'd0;
      end else if (s[31:16] > 16'd255) begin
         return 8'd255;
      end
      return s[23:16];
   endfunction

endpackage

@@ hdl/hdr_pixel_tonemap_lut_core.sv @@
// HDR to SDR pixel tone-mapping core with lookup tables written in-band.
// A pixel result passes the stage registers and then the output register before it appears on rsp_tvalid.
// Throughput: one request per cycle while the skid entry is free; table write requests give no result.
// A two-entry output buffer lets requests flow while one result waits.
// Reset clears the mode register and all valid flags; table contents are
// undefined after reset until written, and there is no clearing pass.

`include "hdr_pixel_tonemap_lut_core_macros.svh"

module hdr_pixel_tonemap_lut_core #(
   parameter int SDR_ENTRIES      = 4096,
   parameter int LINEAR_FRAC_BITS = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: table_address[11:0], table_data[27:12], y_code[37:28], cb_code[47:38],
   // cr_code[57:48], zero fill[63:58]
   input  logic [63:0] req_tdata,
   // tuser: action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: y_out[7:0], cb_out[15:8], cr_out[23:16], red_sdr[31:24],
   // green_sdr[39:32], blue_sdr[47:40]
   output logic [47:0] rsp_tdata
);
   import hdrtm_pkg::*;

   localparam int SDR_AW = $clog2(SDR_ENTRIES);
   localparam int IDX_W  = 35;
   localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(64'd1 << (LINEAR_FRAC_BITS - 1));
   localparam logic [SDR_AW-1:0] SDR_MAX = SDR_AW'(SDR_ENTRIES - 1);

   // Quantizes a linear value to an SDR table index, saturating at the top.
   function automatic logic [SDR_AW-1:0] sdr_index(input logic [16:0] lin);
      logic [IDX_W-1:0] v;
      v = IDX_W'(lin) * IDX_W'(SDR_ENTRIES - 1) + IDX_HALF;
      v = v >> LINEAR_FRAC_BITS;
      if (v > IDX_W'(SDR_ENTRIES - 1)) begin
         return SDR_MAX;
      end
      return v[SDR_AW-1:0];
   endfunction

   // Tables; the linear and SDR tables have one copy per read port.
   logic [15:0] lin_y_mem [1024];
   logic [15:0] lin_r_mem [1024];
   logic [15:0] lin_b_mem [1024];
   logic [7:0]  luma_mem  [1024];
   logic [7:0]  sdr_r_mem [SDR_ENTRIES];
   logic [7:0]  sdr_g_mem [SDR_ENTRIES];
   logic [7:0]  sdr_b_mem [SDR_ENTRIES];

   logic custom_ff;
   logic en;
   item_type item_in;

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   item_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff;
   logic [9:0]  s1_y_ff, s1_pr_ff, s1_pb_ff;
   logic [15:0] s2_ylin_ff, s2_rlin_ff, s2_blin_ff;
   logic [7:0]  s2_luma_ff, s3_luma_ff, s4_luma_ff, s5_luma_ff, s6_luma_ff, s7_luma_ff;
   logic signed [34:0] s3_num_ff, s3_num_in;
   logic [SDR_AW-1:0] s3_ridx_ff, s3_bidx_ff, s4_ridx_ff, s4_bidx_ff;
   logic [16:0] s4_glin_ff, s4_glin_in;
   logic [48:0] g_prod;
   logic [SDR_AW-1:0] s5_ridx_ff, s5_gidx_ff, s5_bidx_ff;
   logic [7:0]  s6_rs_ff, s6_gs_ff, s6_bs_ff;
   logic [7:0]  s7_ys_ff, s7_ys_in, s7_rs_ff, s7_gs_ff, s7_bs_ff;
   logic [25:0] ys_sum;
   logic        sdr_wr_ok;

   logic        res_v;
   logic [47:0] res_in;
   logic        out_v_ff, skid_v_ff;
   logic [47:0] out_ff, skid_ff;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         custom_ff <= 1'b0;
      end else if (csr_wr_en) begin
         custom_ff <= csr_wr_data;
      end
   end

   // The pipeline moves whenever the skid entry is free.
   assign en         = !skid_v_ff;
   assign req_tready = en;

   // Request decode and custom chroma.
   always_comb begin
      item_in.action  = action_type'(req_tuser);
      item_in.addr    = req_tdata[11:0];
      item_in.data    = req_tdata[27:12];
      item_in.custom  = custom_ff;
      item_in.cb_cust = custom_chroma(req_tdata[47:38], CB_SCALE, CB_OFFSET);
      item_in.cr_cust = custom_chroma(req_tdata[57:48], CR_SCALE, CR_OFFSET);
   end

   // Valid flags of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_tvalid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
      end
   end

   // Green numerator and the green recovery from it.
   assign s3_num_in = $signed({3'b0, s2_ylin_ff, 16'b0})
                    - $signed({18'b0, R2020_COEF}) * $signed({19'b0, s2_rlin_ff})
                    - $signed({18'b0, B2020_COEF}) * $signed({19'b0, s2_blin_ff});
   assign g_prod     = 49'(s3_num_ff[31:0]) * 49'(G2020_INV) + (49'd1 << 31);
   assign s4_glin_in = (s3_num_ff > 0) ? g_prod[48:32] : 17'd0;

   // BT.709 luma from the tone-mapped channels.
   assign ys_sum   = 26'(R709_COEF) * 26'(s6_rs_ff) + 26'(G709_COEF) * 26'(s6_gs_ff)
                   + 26'(B709_COEF) * 26'(s6_bs_ff) + 26'd32768;
   assign s7_ys_in = (ys_sum[25:16] > 10'd255) ? 8'd255 : ys_sum[23:16];

   // Payload registers of the stages.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff      <= item_in;
         s1_y_ff    <= req_tdata[37:28];
         s1_pr_ff   <= pq_channel(req_tdata[37:28], req_tdata[57:48], PQ_CR_COEF);
         s1_pb_ff   <= pq_channel(req_tdata[37:28], req_tdata[47:38], PQ_CB_COEF);
         s2_ff      <= s1_ff;
         s3_ff      <= s2_ff;
         s3_luma_ff <= s2_luma_ff;
         s3_num_ff  <= s3_num_in;
         s3_ridx_ff <= sdr_index({1'b0, s2_rlin_ff});
         s3_bidx_ff <= sdr_index({1'b0, s2_blin_ff});
         s4_ff      <= s3_ff;
         s4_luma_ff <= s3_luma_ff;
         s4_glin_ff <= s4_glin_in;
         s4_ridx_ff <= s3_ridx_ff;
         s4_bidx_ff <= s3_bidx_ff;
         s5_ff      <= s4_ff;
         s5_luma_ff <= s4_luma_ff;
         s5_ridx_ff <= s4_ridx_ff;
         s5_gidx_ff <= sdr_index(s4_glin_ff);
         s5_bidx_ff <= s4_bidx_ff;
         s6_ff      <= s5_ff;
         s6_luma_ff <= s5_luma_ff;
         s7_ff      <= s6_ff;
         s7_luma_ff <= s6_luma_ff;
         s7_ys_ff   <= s7_ys_in;
         s7_rs_ff   <= s6_rs_ff;
         s7_gs_ff   <= s6_gs_ff;
         s7_bs_ff   <= s6_bs_ff;
      end
   end

   // Linear and luma tables: read and written in the same stage, so
   // requests see table writes in arrival order.
   always_ff @(posedge clock) begin
      if (en) begin
         if (s1_v_ff && s1_ff.action == ACT_WR_LINEAR) begin
            lin_y_mem[s1_ff.addr[9:0]] <= s1_ff.data;
            lin_r_mem[s1_ff.addr[9:0]] <= s1_ff.data;
            lin_b_mem[s1_ff.addr[9:0]] <= s1_ff.data;
         end
         if (s1_v_ff && s1_ff.action == ACT_WR_LUMA) begin
            luma_mem[s1_ff.addr[9:0]] <= s1_ff.data[7:0];
         end
         s2_ylin_ff <= lin_y_mem[s1_y_ff];
         s2_rlin_ff <= lin_r_mem[s1_pr_ff];
         s2_blin_ff <= lin_b_mem[s1_pb_ff];
         s2_luma_ff <= luma_mem[s1_y_ff];
      end
   end

   // SDR tables, also read and written in one stage.
   assign sdr_wr_ok = s5_v_ff && s5_ff.action == ACT_WR_SDR
                    && 32'(s5_ff.addr) < 32'(SDR_ENTRIES);

   always_ff @(posedge clock) begin
      if (en) begin
         if (sdr_wr_ok) begin
            sdr_r_mem[SDR_AW'(s5_ff.addr)] <= s5_ff.data[7:0];
            sdr_g_mem[SDR_AW'(s5_ff.addr)] <= s5_ff.data[7:0];
            sdr_b_mem[SDR_AW'(s5_ff.addr)] <= s5_ff.data[7:0];
         end
         s6_rs_ff <= sdr_r_mem[s5_ridx_ff];
         s6_gs_ff <= sdr_g_mem[s5_gidx_ff];
         s6_bs_ff <= sdr_b_mem[s5_bidx_ff];
      end
   end

   // Result assembly with BT.709 chroma or the custom path.
   assign res_v = s7_v_ff && s7_ff.action == ACT_PIXEL;

   always_comb begin
      if (s7_ff.custom) begin
         res_in = {24'd0, s7_ff.cr_cust, s7_ff.cb_cust, s7_luma_ff};
      end else begin
         res_in = {s7_bs_ff, s7_gs_ff, s7_rs_ff,
                   chroma_709(s7_rs_ff, s7_ys_ff, CR709_COEF),
                   chroma_709(s7_bs_ff, s7_ys_ff, CB709_COEF),
                   s7_ys_ff};
      end
   end

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_tready) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (res_v) begin
         if (!out_v_ff || rsp_tready) begin
            out_ff   <= res_in;
            out_v_ff <= 1'b1;
         end else begin
            skid_ff   <= res_in;
            skid_v_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;

   // A buffered result always has one in the output register ahead of it.
   `HTM_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_v_ff, out_v_ff,
                    "skid without output")
   // A new result arriving at a stalled output must land in the skid entry.
   `HTM_ASSERT_NEXT(a_skid_catch, clock, reset,
                    res_v && en && out_v_ff && !rsp_tready, skid_v_ff,
                    "result lost at stall")
   // A taken output drains the skid entry into the output register in the next cycle.
   `HTM_ASSERT_NEXT(a_skid_drain, clock, reset, skid_v_ff && rsp_tready,
                    !skid_v_ff && out_v_ff, "skid not drained")

endmodule
